FILE: sv/zot_pkg.sv
// Shared types and codes for the layer z-order table.
package zot_pkg;

  localparam int unsigned ZW  = 32;
  localparam int unsigned IDW = 32;

  typedef enum logic [2:0] {
    OP_WRITE   = 3'd0,
    OP_SWAP    = 3'd1,
    OP_REVERSE = 3'd2,
    OP_ROT_UP  = 3'd3,
    OP_ROT_DN  = 3'd4,
    OP_READ    = 3'd5
  } op_t;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_WR     = 12'b0000_0000_0010,
    ST_SRCH   = 12'b0000_0000_0100,
    ST_SW_RDA = 12'b0000_0000_1000,
    ST_SW_RDB = 12'b0000_0001_0000,
    ST_SW_WRA = 12'b0000_0010_0000,
    ST_SW_WRB = 12'b0000_0100_0000,
    ST_GATHER = 12'b0000_1000_0000,
    ST_SCATTR = 12'b0001_0000_0000,
    ST_RD_ISS = 12'b0010_0000_0000,
    ST_RD_DAT = 12'b0100_0000_0000,
    ST_RESP   = 12'b1000_0000_0000
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             visible;
    logic [IDW-1:0]   id;
    logic signed [ZW-1:0] z;
  } slot_rec_t;

  typedef struct packed {
    op_t              op;
    logic [3:0]       slot;
    logic [IDW-1:0]   id_a;
    logic [IDW-1:0]   id_b;
    logic             valid;
    logic             visible;
    logic signed [ZW-1:0] z;
  } req_t;

  typedef struct packed {
    logic      status;
    slot_rec_t rec;
  } res_t;

endpackage

FILE: sv/zot_store.sv
// Slot table storage: id and z memories plus per-slot flag registers.
module zot_store #(
  parameter int LAYERS = 16,
  parameter int IW     = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [IW-1:0]        rd_addr,
  output zot_pkg::slot_rec_t   rd_rec,
  input  logic                 wr_all,
  input  logic                 wr_z,
  input  logic [IW-1:0]        wr_addr,
  input  zot_pkg::slot_rec_t   wr_rec,
  output logic [LAYERS-1:0]    act_vec
);

  logic [zot_pkg::IDW-1:0]    id_mem [LAYERS];
  logic [zot_pkg::ZW-1:0]     z_mem  [LAYERS];
  logic [LAYERS-1:0]          valid_r;
  logic [LAYERS-1:0]          vis_r;
  logic [LAYERS-1:0]          wrt_r;
  logic [zot_pkg::IDW-1:0]    id_rd_r;
  logic [zot_pkg::ZW-1:0]     z_rd_r;
  logic                       valid_rd_r;
  logic                       vis_rd_r;
  logic                       wrt_rd_r;

  // Write and read the payload memories
  always_ff @(posedge clk) begin
    if (wr_all) begin
      id_mem[wr_addr] <= wr_rec.id;
    end
    if (wr_all || wr_z) begin
      z_mem[wr_addr] <= wr_rec.z;
    end
    id_rd_r    <= id_mem[rd_addr];
    z_rd_r     <= z_mem[rd_addr];
    valid_rd_r <= valid_r[rd_addr];
    vis_rd_r   <= vis_r[rd_addr];
    wrt_rd_r   <= wrt_r[rd_addr];
  end

  // Flags; a slot never written reads as all zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vis_r   <= '0;
      wrt_r   <= '0;
    end else if (wr_all) begin
      valid_r[wr_addr] <= wr_rec.valid;
      vis_r[wr_addr]   <= wr_rec.visible;
      wrt_r[wr_addr]   <= 1'b1;
    end
  end

  always_comb begin
    rd_rec.valid   = valid_rd_r;
    rd_rec.visible = vis_rd_r;
    rd_rec.id      = wrt_rd_r ? id_rd_r : '0;
    rd_rec.z       = wrt_rd_r ? z_rd_r : '0;
  end

  assign act_vec = valid_r & vis_r;

endmodule

FILE: sv/zot_seq.sv
// Operation sequencer: slot walks, swap search, z gather and scatter.
module zot_seq #(
  parameter int LAYERS = 16,
  parameter int IW     = 4,
  parameter int CW     = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 req_accept,
  input  zot_pkg::req_t        req_in,
  output logic                 in_ready,
  input  logic                 out_free,
  output logic                 out_load,
  output zot_pkg::res_t        res,
  output logic [IW-1:0]        rd_addr,
  input  zot_pkg::slot_rec_t   rd_rec,
  output logic                 wr_all,
  output logic                 wr_z,
  output logic [IW-1:0]        wr_addr,
  output zot_pkg::slot_rec_t   wr_rec,
  input  logic [LAYERS-1:0]    act_vec
);

  zot_pkg::state_t         state_r, state_nxt;
  zot_pkg::req_t           req_r;
  zot_pkg::res_t           res_r;
  logic [CW-1:0]           i_r;
  logic [CW-1:0]           j_r;
  logic [CW-1:0]           n_r;
  logic                    rd_pend_r;
  logic [IW-1:0]           rd_idx_r;
  logic                    fa_r, fb_r;
  logic [IW-1:0]           a_r, b_r;
  logic [zot_pkg::ZW-1:0]  za_r;
  logic                    wp_pend_r;
  logic [IW-1:0]           wp_addr_r;
  logic [zot_pkg::ZW-1:0]  zbuf [LAYERS];
  logic [zot_pkg::ZW-1:0]  zbuf_rd_r;
  logic [CW-1:0]           src;
  logic                    walking;
  logic                    slot_ok;
  logic [IW-1:0]           i_idx;
  logic [IW-1:0]           slot_idx;

  assign walking  = (i_r < CW'(LAYERS));
  assign i_idx    = i_r[IW-1:0];
  assign slot_idx = IW'(req_r.slot);
  assign slot_ok  = ({28'd0, req_r.slot} < 32'(LAYERS));
  assign in_ready = (state_r == zot_pkg::ST_IDLE);
  assign res      = res_r;

  // Source position in the gathered list for active slot j
  always_comb begin
    unique case (req_r.op)
      zot_pkg::OP_REVERSE: src = n_r - CW'(1) - j_r;
      zot_pkg::OP_ROT_UP:  src = (j_r + CW'(1) == n_r) ? '0 : j_r + CW'(1);
      default:             src = (j_r == '0) ? n_r - CW'(1) : j_r - CW'(1);
    endcase
  end

  // Next state and storage controls
  always_comb begin
    state_nxt = state_r;
    rd_addr   = i_idx;
    wr_all    = 1'b0;
    wr_z      = 1'b0;
    wr_addr   = slot_idx;
    wr_rec    = '{valid: req_r.valid, visible: req_r.visible, id: req_r.id_a, z: req_r.z};
    out_load  = 1'b0;
    unique case (state_r)
      zot_pkg::ST_IDLE: begin
        if (req_accept) begin
          unique case (req_in.op)
            zot_pkg::OP_WRITE:   state_nxt = zot_pkg::ST_WR;
            zot_pkg::OP_SWAP:    state_nxt = (req_in.id_a == req_in.id_b) ?
                                             zot_pkg::ST_RESP : zot_pkg::ST_SRCH;
            zot_pkg::OP_REVERSE,
            zot_pkg::OP_ROT_UP,
            zot_pkg::OP_ROT_DN:  state_nxt = zot_pkg::ST_GATHER;
            zot_pkg::OP_READ:    state_nxt = zot_pkg::ST_RD_ISS;
            default:             state_nxt = zot_pkg::ST_RESP;
          endcase
        end
      end
      zot_pkg::ST_WR: begin
        wr_all    = slot_ok;
        state_nxt = zot_pkg::ST_RESP;
      end
      zot_pkg::ST_SRCH: begin
        if (!walking && !rd_pend_r) begin
          state_nxt = (fa_r && fb_r) ? zot_pkg::ST_SW_RDA : zot_pkg::ST_RESP;
        end
      end
      zot_pkg::ST_SW_RDA: begin
        rd_addr   = a_r;
        state_nxt = zot_pkg::ST_SW_RDB;
      end
      zot_pkg::ST_SW_RDB: begin
        rd_addr   = b_r;
        state_nxt = zot_pkg::ST_SW_WRA;
      end
      zot_pkg::ST_SW_WRA: begin
        wr_z      = 1'b1;
        wr_addr   = a_r;
        wr_rec.z  = rd_rec.z;
        state_nxt = zot_pkg::ST_SW_WRB;
      end
      zot_pkg::ST_SW_WRB: begin
        wr_z      = 1'b1;
        wr_addr   = b_r;
        wr_rec.z  = za_r;
        state_nxt = zot_pkg::ST_RESP;
      end
      zot_pkg::ST_GATHER: begin
        if (!walking && !rd_pend_r) begin
          state_nxt = (n_r < CW'(2)) ? zot_pkg::ST_RESP : zot_pkg::ST_SCATTR;
        end
      end
      zot_pkg::ST_SCATTR: begin
        wr_z     = wp_pend_r;
        wr_addr  = wp_addr_r;
        wr_rec.z = zbuf_rd_r;
        if (!walking && !wp_pend_r) begin
          state_nxt = zot_pkg::ST_RESP;
        end
      end
      zot_pkg::ST_RD_ISS: begin
        rd_addr   = slot_idx;
        state_nxt = zot_pkg::ST_RD_DAT;
      end
      zot_pkg::ST_RD_DAT: begin
        state_nxt = zot_pkg::ST_RESP;
      end
      zot_pkg::ST_RESP: begin
        out_load = out_free;
        if (out_free) begin
          state_nxt = zot_pkg::ST_IDLE;
        end
      end
      default: state_nxt = zot_pkg::ST_IDLE;
    endcase
  end

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= zot_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Gather buffer of active z values
  always_ff @(posedge clk) begin
    if (state_r == zot_pkg::ST_GATHER && rd_pend_r && rd_rec.valid && rd_rec.visible) begin
      zbuf[n_r[IW-1:0]] <= rd_rec.z;
    end
    zbuf_rd_r <= zbuf[src[IW-1:0]];
  end

  // Walk counters, search results and the response
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      wp_pend_r <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      n_r       <= '0;
      fa_r      <= 1'b0;
      fb_r      <= 1'b0;
    end else begin
      unique case (state_r)
        zot_pkg::ST_IDLE: begin
          if (req_accept) begin
            req_r     <= req_in;
            res_r     <= '0;
            i_r       <= '0;
            j_r       <= '0;
            n_r       <= '0;
            fa_r      <= 1'b0;
            fb_r      <= 1'b0;
            rd_pend_r <= 1'b0;
            wp_pend_r <= 1'b0;
          end
        end
        zot_pkg::ST_SRCH, zot_pkg::ST_GATHER: begin
          rd_pend_r <= walking;
          rd_idx_r  <= i_idx;
          if (walking) begin
            i_r <= i_r + CW'(1);
          end
          if (rd_pend_r) begin
            if (state_r == zot_pkg::ST_SRCH) begin
              if (!fa_r && rd_rec.valid && rd_rec.id == req_r.id_a) begin
                fa_r <= 1'b1;
                a_r  <= rd_idx_r;
              end
              if (!fb_r && rd_rec.valid && rd_rec.id == req_r.id_b) begin
                fb_r <= 1'b1;
                b_r  <= rd_idx_r;
              end
            end else if (rd_rec.valid && rd_rec.visible) begin
              n_r <= n_r + CW'(1);
            end
          end
          if (!walking && !rd_pend_r) begin
            i_r <= '0;
            if (state_r == zot_pkg::ST_SRCH) begin
              res_r.status <= !(fa_r && fb_r);
            end
          end
        end
        zot_pkg::ST_SW_RDB: begin
          za_r <= rd_rec.z;
        end
        zot_pkg::ST_SCATTR: begin
          wp_pend_r <= walking && act_vec[i_idx];
          wp_addr_r <= i_idx;
          if (walking) begin
            i_r <= i_r + CW'(1);
            if (act_vec[i_idx]) begin
              j_r <= j_r + CW'(1);
            end
          end
        end
        zot_pkg::ST_RD_DAT: begin
          if (slot_ok) begin
            res_r.rec <= rd_rec;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= CW'(LAYERS))
    else $error("gather count exceeds table size");

  a_scatter_active: assert property (@(posedge clk) disable iff (!rst_n)
    wp_pend_r |-> act_vec[wp_addr_r])
    else $error("scatter writes an inactive slot");

  a_swap_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == zot_pkg::ST_SW_WRA) |-> (fa_r && fb_r && a_r != b_r))
    else $error("swap writes without two distinct matches");

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    req_accept |=> !in_ready)
    else $error("ready again right after accepting a request");
`endif

endmodule

FILE: sv/layer_zorder_table.sv
// Layer z-order table: one request in, one response out, under a walk sequencer.
// One request at a time; the next is taken in the cycle after the response loads.
// Synchronous active-low reset clears all slot flags; unwritten slots read as zero.
module layer_zorder_table #(
  parameter int LAYERS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // [3:0] slot, [35:4] id_a, [67:36] id_b, [68] in_valid, [69] in_visible,
  // [101:70] in_z, [103:102] zero
  input  logic [103:0]  in_tdata,
  // [2:0] operation
  input  logic [2:0]    in_tuser,
  output logic          out_tvalid,
  input  logic          out_tready,
  // [0] status, [1] out_valid, [2] out_visible, [34:3] out_id, [66:35] out_z,
  // [71:67] zero
  output logic [71:0]   out_tdata
);

  localparam int IW = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int CW = $clog2(LAYERS + 1);

  zot_pkg::req_t       req_in;
  zot_pkg::res_t       res;
  zot_pkg::slot_rec_t  rd_rec;
  zot_pkg::slot_rec_t  wr_rec;
  logic [IW-1:0]       rd_addr;
  logic [IW-1:0]       wr_addr;
  logic                wr_all;
  logic                wr_z;
  logic [LAYERS-1:0]   act_vec;
  logic                out_load;
  logic                out_free;
  logic                out_tvalid_r;
  logic [71:0]         out_tdata_r;

  // Unpack the request
  always_comb begin
    req_in.op      = zot_pkg::op_t'(in_tuser);
    req_in.slot    = in_tdata[3:0];
    req_in.id_a    = in_tdata[35:4];
    req_in.id_b    = in_tdata[67:36];
    req_in.valid   = in_tdata[68];
    req_in.visible = in_tdata[69];
    req_in.z       = in_tdata[101:70];
  end

  zot_store #(.LAYERS(LAYERS), .IW(IW)) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_rec  (rd_rec),
    .wr_all  (wr_all),
    .wr_z    (wr_z),
    .wr_addr (wr_addr),
    .wr_rec  (wr_rec),
    .act_vec (act_vec)
  );

  zot_seq #(.LAYERS(LAYERS), .IW(IW), .CW(CW)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_accept (in_tvalid && in_tready),
    .req_in     (req_in),
    .in_ready   (in_tready),
    .out_free   (out_free),
    .out_load   (out_load),
    .res        (res),
    .rd_addr    (rd_addr),
    .rd_rec     (rd_rec),
    .wr_all     (wr_all),
    .wr_z       (wr_z),
    .wr_addr    (wr_addr),
    .wr_rec     (wr_rec),
    .act_vec    (act_vec)
  );

  assign out_free = !out_tvalid_r || out_tready;

  // Hold the response until the sink takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {5'd0, res.rec.z, res.rec.id, res.rec.visible,
                      res.rec.valid, res.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

FILE: tb/sv/layer_zorder_table_tb.sv
// Self-checking stream testbench for the layer z-order table.
`timescale 1ns / 100ps

module layer_zorder_table_tb;

  localparam int LAYERS      = 16;
  localparam int RAND_ITEMS  = 400;
  localparam int QUIET_TAIL  = 50;
  localparam int MAX_CYCLES  = 200000;
  localparam int TAIL_CYCLES = 2 * LAYERS + 10;
  localparam int LONG_HOLD   = 300;
  localparam int ID_POOL     = 8;

  // Codes the block treats as no-ops
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic [3:0]         slot;
    logic [31:0]        id_a;
    logic [31:0]        id_b;
    logic               vld;
    logic               vis;
    logic signed [31:0] z;
    logic               drain_first;
  } layer_req_t;

  typedef struct packed {
    logic               status;
    logic               vld;
    logic               vis;
    logic [31:0]        id;
    logic signed [31:0] z;
  } layer_resp_t;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata   = '0;
  logic [2:0]   in_tuser   = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [71:0]  out_tdata;

  layer_req_t  req_pending[$];
  layer_resp_t resp_expected[$];

  // Shadow copy of the slot table
  logic               shadow_valid[LAYERS];
  logic               shadow_vis[LAYERS];
  logic [31:0]        shadow_id[LAYERS];
  logic signed [31:0] shadow_z[LAYERS];

  logic [31:0] id_pool[ID_POOL];

  int total_reqs;
  int n_sent;
  int n_results;
  int n_errors;
  int n_mismatch;
  int n_swap_miss;
  int n_permute_moved;
  int n_reads;
  int cycles;
  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_done;

  layer_zorder_table #(.LAYERS(LAYERS)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Lowest valid slot holding the id, or -1
  function automatic int find_layer(logic [31:0] id);
    for (int i = 0; i < LAYERS; i++) begin
      if (shadow_valid[i] && shadow_id[i] == id) return i;
    end
    return -1;
  endfunction

  // Permute the z values of the valid, visible slots in slot order
  function automatic void permute_active_z(logic [2:0] op);
    int                 idx[LAYERS];
    logic signed [31:0] zv[LAYERS];
    int                 n;
    n = 0;
    for (int i = 0; i < LAYERS; i++) begin
      if (shadow_valid[i] && shadow_vis[i]) begin
        idx[n] = i;
        zv[n]  = shadow_z[i];
        n++;
      end
    end
    if (n < 2) return;
    n_permute_moved++;
    for (int i = 0; i < n; i++) begin
      case (op)
        zot_pkg::OP_REVERSE: shadow_z[idx[i]] = zv[n - 1 - i];
        zot_pkg::OP_ROT_UP:  shadow_z[idx[i]] = zv[(i + 1) % n];
        default:             shadow_z[idx[i]] = zv[(i + n - 1) % n];
      endcase
    end
  endfunction

  // Apply one request to the shadow table and return the response it must give
  function automatic layer_resp_t predict_table_response(layer_req_t r);
    layer_resp_t        p;
    int                 a;
    int                 b;
    logic signed [31:0] t;
    p = '0;
    case (r.op)
      zot_pkg::OP_WRITE: begin
        if (int'(r.slot) < LAYERS) begin
          shadow_valid[r.slot] = r.vld;
          shadow_vis[r.slot]   = r.vis;
          shadow_id[r.slot]    = r.id_a;
          shadow_z[r.slot]     = r.z;
        end
      end
      zot_pkg::OP_SWAP: begin
        if (r.id_a != r.id_b) begin
          a = find_layer(r.id_a);
          b = find_layer(r.id_b);
          if (a < 0 || b < 0) begin
            p.status = 1'b1;
            n_swap_miss++;
          end else begin
            t           = shadow_z[a];
            shadow_z[a] = shadow_z[b];
            shadow_z[b] = t;
          end
        end
      end
      zot_pkg::OP_REVERSE, zot_pkg::OP_ROT_UP, zot_pkg::OP_ROT_DN: permute_active_z(r.op);
      zot_pkg::OP_READ: begin
        n_reads++;
        if (int'(r.slot) < LAYERS) begin
          p.vld = shadow_valid[r.slot];
          p.vis = shadow_vis[r.slot];
          p.id  = shadow_id[r.slot];
          p.z   = shadow_z[r.slot];
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic logic [103:0] pack_request(layer_req_t r);
    return {2'b00, r.z, r.vis, r.vld, r.id_b, r.id_a, r.slot};
  endfunction

  task automatic queue_req(logic [2:0] op, logic [3:0] slot, logic [31:0] id_a,
                           logic [31:0] id_b, logic vld, logic vis, logic signed [31:0] z);
    layer_req_t r;
    r.op          = op;
    r.slot        = slot;
    r.id_a        = id_a;
    r.id_b        = id_b;
    r.vld         = vld;
    r.vis         = vis;
    r.z           = z;
    r.drain_first = 1'b0;
    req_pending.push_back(r);
  endtask

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 9) < 8) return id_pool[$urandom_range(0, ID_POOL - 1)];
    return $urandom;
  endfunction

  // Mix of writes, id-hitting swaps, permutes, reads and reserved codes, with noise in unused fields
  function automatic layer_req_t random_request();
    layer_req_t r;
    int         pick;
    r.op          = zot_pkg::OP_WRITE;
    r.slot        = 4'($urandom_range(0, 15));
    r.id_a        = $urandom;
    r.id_b        = $urandom;
    r.vld         = 1'($urandom);
    r.vis         = 1'($urandom);
    r.z           = $urandom;
    r.drain_first = 1'b0;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      r.op   = zot_pkg::OP_WRITE;
      r.id_a = pick_id();
      r.vld  = ($urandom_range(0, 9) < 8);
      r.vis  = ($urandom_range(0, 3) != 0);
    end else if (pick < 50) begin
      r.op   = zot_pkg::OP_SWAP;
      r.id_a = pick_id();
      r.id_b = ($urandom_range(0, 9) == 0) ? r.id_a : pick_id();
    end else if (pick < 58) begin
      r.op = zot_pkg::OP_REVERSE;
    end else if (pick < 66) begin
      r.op = zot_pkg::OP_ROT_UP;
    end else if (pick < 74) begin
      r.op = zot_pkg::OP_ROT_DN;
    end else if (pick < 96) begin
      r.op = zot_pkg::OP_READ;
    end else begin
      r.op = ($urandom_range(0, 1) != 0) ? OP_RSVD6 : OP_RSVD7;
    end
    return r;
  endfunction

  // Request driver: hold each request until accepted, idle in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        resp_expected.push_back(predict_table_response(req_pending.pop_front()));
        n_sent++;
      end
      if (in_tvalid && !in_tready) begin
        // hold the offered request
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (req_pending.size() > 0 && req_pending[0].drain_first &&
                   resp_expected.size() != 0) begin
        in_tvalid <= 1'b0;
      end else if (n_sent < total_reqs - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 14);
        in_tvalid <= 1'b0;
      end else if (req_pending.size() > 0) begin
        req_pending[0].drain_first = 1'b0;
        in_tvalid <= 1'b1;
        in_tdata  <= pack_request(req_pending[0]);
        in_tuser  <= req_pending[0].op;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  task automatic check_response(logic [71:0] data);
    layer_resp_t got;
    layer_resp_t want;
    got.status = data[0];
    got.vld    = data[1];
    got.vis    = data[2];
    got.id     = data[34:3];
    got.z      = data[66:35];
    n_results++;
    if (resp_expected.size() == 0) begin
      n_errors++;
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("%0t: response with no request pending: status=%0b id=%h z=%0d",
                 $realtime, got.status, got.id, got.z);
      return;
    end
    want = resp_expected.pop_front();
    if (got.status != want.status || got.vld != want.vld || got.vis != want.vis ||
        got.id != want.id || got.z != want.z) begin
      n_errors++;
      n_mismatch++;
      if (n_mismatch <= 10) begin
        $display("%0t: response %0d mismatch: exp st=%0b v=%0b vis=%0b id=%h z=%0d",
                 $realtime, n_results, want.status, want.vld, want.vis, want.id, want.z);
        $display("    got st=%0b v=%0b vis=%0b id=%h z=%0d",
                 got.status, got.vld, got.vis, got.id, got.z);
      end
    end
  endtask

  // Response monitor and ready control, with one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_tvalid && out_tready) check_response(out_tdata);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && n_results >= 100) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (n_results < total_reqs - QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Run watchdog
  initial begin
    cycles = 0;
    while (cycles < MAX_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding", cycles,
             resp_expected.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    layer_req_t r;
    for (int i = 0; i < LAYERS; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_vis[i]   = 1'b0;
      shadow_id[i]    = '0;
      shadow_z[i]     = '0;
    end
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < ID_POOL; i++) id_pool[i] = $urandom;

    // Directed: empty and single-slot permutes, field extremes, every swap outcome
    queue_req(zot_pkg::OP_REVERSE, 4'd0, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_READ, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, -1);
    queue_req(zot_pkg::OP_WRITE, 4'd0, 32'hFFFF_FFFF, '0, 1'b1, 1'b1, 32'sh7FFF_FFFF);
    queue_req(zot_pkg::OP_ROT_DN, 4'd0, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_WRITE, 4'd15, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
              32'sh8000_0000);
    queue_req(zot_pkg::OP_WRITE, 4'd7, 32'h1234_5678, '0, 1'b1, 1'b0, -1);
    queue_req(zot_pkg::OP_WRITE, 4'd3, 32'hAAAA_AAAA, '0, 1'b0, 1'b1, 5);
    queue_req(zot_pkg::OP_SWAP, 4'd0, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_SWAP, 4'd0, 32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_SWAP, 4'd0, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_SWAP, 4'd0, 32'h1234_5678, 32'h0000_0000, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_REVERSE, 4'd0, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_ROT_UP, 4'd0, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_WRITE, 4'd8, 32'h5555_5555, '0, 1'b1, 1'b1, 100);
    queue_req(zot_pkg::OP_WRITE, 4'd9, 32'h5555_5555, '0, 1'b1, 1'b1, -100);
    queue_req(zot_pkg::OP_ROT_UP, 4'd0, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_ROT_DN, 4'd0, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_REVERSE, 4'd0, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_SWAP, 4'd0, 32'h5555_5555, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    queue_req(OP_RSVD6, 4'd5, $urandom, $urandom, 1'b1, 1'b1, $urandom);
    queue_req(OP_RSVD7, 4'd10, $urandom, $urandom, 1'b1, 1'b1, $urandom);
    queue_req(zot_pkg::OP_READ, 4'd8, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_READ, 4'd9, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_READ, 4'd15, '0, '0, 1'b0, 1'b0, '0);
    queue_req(zot_pkg::OP_READ, 4'd7, '0, '0, 1'b0, 1'b0, '0);

    for (int i = 0; i < RAND_ITEMS; i++) begin
      r = random_request();
      // pause the sender once until the table has answered everything
      if (i == RAND_ITEMS / 2) r.drain_first = 1'b1;
      req_pending.push_back(r);
    end
    total_reqs = req_pending.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    wait (n_sent == total_reqs);
    wait (resp_expected.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d requests: %0d reads, %0d swaps with a missing id,",
             n_sent, n_reads, n_swap_miss);
    $display("%0d permutes over two or more active slots, %0d responses checked",
             n_permute_moved, n_results);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
